@@ rtl/rjfh_pkg.sv @@
// shared constants and register codes for the rtp jpeg fragment header engine
package rjfh_pkg;

	localparam int MAX_FRAGMENTS = 64;
	localparam int FRAG_W        = $clog2(MAX_FRAGMENTS + 1);

	localparam int LEN_W   = 24;
	localparam int DIM_W   = 16;
	localparam int UNIT_W  = 8;
	localparam int SEQ_W   = 16;
	localparam int TS_W    = 32;
	localparam int STEP_W  = 17;
	localparam int LIM_W   = 13;
	localparam int CNT_W   = 32;
	localparam int CFG_W   = 32;
	localparam int IDX_W   = 3;
	localparam int SPAN_W  = LIM_W + FRAG_W;

	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 184;

	localparam logic [LIM_W-1:0]  HDR_BYTES   = 13'd20;
	localparam logic [LIM_W-1:0]  LIMIT_MAX   = 13'd4096;
	localparam logic [LIM_W-1:0]  LIMIT_RST   = 13'd1400;
	localparam logic [STEP_W-1:0] STEP_RST    = 17'd3000;
	localparam logic [SPAN_W-1:0] MAX_FRAG_V  = SPAN_W'(MAX_FRAGMENTS);

	localparam logic [IDX_W-1:0] REG_SSRC      = 3'd0;
	localparam logic [IDX_W-1:0] REG_INIT_SEQ  = 3'd1;
	localparam logic [IDX_W-1:0] REG_INIT_TS   = 3'd2;
	localparam logic [IDX_W-1:0] REG_TS_STEP   = 3'd3;
	localparam logic [IDX_W-1:0] REG_PAY_LIMIT = 3'd4;

endpackage

@@ rtl/rtp_jpeg_fragment_header_engine_top.sv @@
// rtp jpeg fragment header engine: frame descriptor in, one header word per fragment out
// path: an accepted frame is checked, then the emit state loads each header word into the output register
// throughput: one header word per cycle while the output is taken; each frame is first
// checked in the shared subtract and compare unit, an empty frame ends there and an oversize
// frame yields one error word; the next frame is taken once the last word is loaded for output
// reset: arst_n clears control, counters and registers; frame and output data are not reset
module rtp_jpeg_fragment_header_engine_top
	import rjfh_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [IDX_W-1:0]      cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// frame_bytes, frame_width, frame_height
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// sequence_number, rtp_time, fragment_offset, fragment_length, width_units,
	// height_units, packet_size, packets_sent, octets_sent, zero fill
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tlast,
	// oversize_error
	output logic                  m_tuser
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CHECK = 2'd1;
	localparam logic [1:0] ST_EMIT  = 2'd2;
	localparam logic [1:0] ST_ERR   = 2'd3;

	logic [1:0]        state_q;
	logic [CFG_W-1:0]  ssrc_q;
	logic [STEP_W-1:0] step_q;
	logic [LIM_W-1:0]  limit_q;
	logic [SEQ_W-1:0]  seq_q;
	logic [TS_W-1:0]   ts_q;
	logic [CNT_W-1:0]  pkt_q;
	logic [CNT_W-1:0]  oct_q;

	logic [LEN_W-1:0]  len_q;
	logic [UNIT_W-1:0] wu_q;
	logic [UNIT_W-1:0] hu_q;
	logic [LIM_W-1:0]  lim_q;
	logic [LEN_W-1:0]  off_q;

	logic              out_valid_q;
	logic              out_last_q;
	logic              out_err_q;
	logic [SEQ_W-1:0]  o_seq_q;
	logic [TS_W-1:0]   o_ts_q;
	logic [LEN_W-1:0]  o_off_q;
	logic [LIM_W-1:0]  o_len_q;
	logic [UNIT_W-1:0] o_wu_q;
	logic [UNIT_W-1:0] o_hu_q;
	logic [LIM_W-1:0]  o_psize_q;
	logic [CNT_W-1:0]  o_pkt_q;
	logic [CNT_W-1:0]  o_oct_q;

	logic              in_fire;
	logic              out_free;
	logic [LIM_W-1:0]  eff_lim;
	logic [SPAN_W-1:0] span;
	logic              oversize;
	logic [LEN_W-1:0]  rem;
	logic              last_frag;
	logic [LIM_W-1:0]  flen;
	logic [LIM_W-1:0]  psize;
	logic [LEN_W-1:0]  off_next;

	assign in_fire  = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		if (limit_q == '0) begin
			eff_lim = LIM_W'(1);
		end else if (limit_q > LIMIT_MAX) begin
			eff_lim = LIMIT_MAX;
		end else begin
			eff_lim = limit_q;
		end
	end

	// shared unit: remaining bytes and compare against the limit
	assign span      = SPAN_W'(lim_q) * MAX_FRAG_V;
	assign oversize  = len_q > LEN_W'(span);
	assign rem       = len_q - off_q;
	assign last_frag = rem <= LEN_W'(lim_q);
	assign flen      = last_frag ? rem[LIM_W-1:0] : lim_q;
	assign psize     = flen + HDR_BYTES;
	assign off_next  = off_q + LEN_W'(lim_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ssrc_q      <= '0;
			step_q      <= STEP_RST;
			limit_q     <= LIMIT_RST;
			seq_q       <= '0;
			ts_q        <= '0;
			pkt_q       <= '0;
			oct_q       <= '0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
			out_err_q   <= 1'b0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_SSRC:      ssrc_q  <= cfg_data;
					REG_INIT_SEQ:  seq_q   <= cfg_data[SEQ_W-1:0];
					REG_INIT_TS:   ts_q    <= cfg_data[TS_W-1:0];
					REG_TS_STEP:   step_q  <= cfg_data[STEP_W-1:0];
					REG_PAY_LIMIT: limit_q <= cfg_data[LIM_W-1:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (oversize) begin
						state_q <= ST_ERR;
					end else begin
						ts_q <= ts_q + TS_W'(step_q);
						state_q <= (len_q == '0) ? ST_IDLE : ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_last_q  <= last_frag;
						out_err_q   <= 1'b0;
						pkt_q       <= pkt_q + CNT_W'(1);
						oct_q       <= oct_q + CNT_W'(psize);
						seq_q       <= seq_q + SEQ_W'(1);
						if (last_frag) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_ERR: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_last_q  <= 1'b0;
						out_err_q   <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			len_q <= s_tdata[LEN_W-1:0];
			wu_q  <= s_tdata[LEN_W+3 +: UNIT_W];
			hu_q  <= s_tdata[LEN_W+DIM_W+3 +: UNIT_W];
			lim_q <= eff_lim;
			off_q <= '0;
		end else if (state_q == ST_EMIT && out_free) begin
			off_q <= off_next;
		end
		if (state_q == ST_EMIT && out_free) begin
			o_seq_q   <= seq_q;
			o_ts_q    <= ts_q;
			o_off_q   <= off_q;
			o_len_q   <= flen;
			o_wu_q    <= wu_q;
			o_hu_q    <= hu_q;
			o_psize_q <= psize;
			o_pkt_q   <= pkt_q + CNT_W'(1);
			o_oct_q   <= oct_q + CNT_W'(psize);
		end else if (state_q == ST_ERR && out_free) begin
			o_seq_q   <= '0;
			o_ts_q    <= '0;
			o_off_q   <= '0;
			o_len_q   <= '0;
			o_wu_q    <= '0;
			o_hu_q    <= '0;
			o_psize_q <= '0;
			o_pkt_q   <= '0;
			o_oct_q   <= '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_err_q;
	assign m_tdata  = {6'd0, o_oct_q, o_pkt_q, o_psize_q, o_hu_q, o_wu_q, o_len_q,
		o_off_q, o_ts_q, o_seq_q};

endmodule
